FILE: rtl/lfsc_pkg.sv
// ============================================================================
// lfsc_pkg - shared types and constants
// Constants, action and class codes for the line-follow steering controller.
// ============================================================================
package lfsc_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int SAMPLE_BITS = 10;
    localparam int THR_REG_BITS = 40;
    localparam int INTEGRAL_LIMIT = 5000;
    localparam logic [31:0] JCT_SETTLE_MS = 32'd150;
    localparam logic [31:0] DEND_SETTLE_MS = 32'd200;
    localparam logic [31:0] ARM_TIMEOUT = 32'd1000;

    // divide by 100 as (x * ceil(2^28 / 100)) >> 28, exact for x below 2^21
    localparam logic [21:0] CORR_RECIP = 22'd2684355;
    localparam int CORR_SHIFT = 28;

    // register indexes
    localparam logic [2:0] REG_THR_LO = 3'd0;
    localparam logic [2:0] REG_THR_HI = 3'd1;
    localparam logic [2:0] REG_KP = 3'd2;
    localparam logic [2:0] REG_KI = 3'd3;
    localparam logic [2:0] REG_KD = 3'd4;
    localparam logic [2:0] REG_MAXSPD = 3'd5;
    localparam logic [2:0] REG_TURN = 3'd6;

    // actions
    localparam logic [2:0] ACT_DRIVE = 3'd0;
    localparam logic [2:0] ACT_LEFT = 3'd1;
    localparam logic [2:0] ACT_RIGHT = 3'd2;
    localparam logic [2:0] ACT_STRAIGHT = 3'd3;
    localparam logic [2:0] ACT_SPIN_CCW = 3'd4;
    localparam logic [2:0] ACT_SPIN_CW = 3'd5;

    // pattern classes
    localparam logic [1:0] CLS_NORMAL = 2'd0;
    localparam logic [1:0] CLS_DARK = 2'd1;
    localparam logic [1:0] CLS_LIGHT = 2'd2;
    localparam logic [1:0] CLS_CENTRE = 2'd3;

    // turn preferences
    localparam logic [1:0] PREF_LEFT = 2'd0;
    localparam logic [1:0] PREF_RIGHT = 2'd1;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_LANE = 7'b0000010,
        ST_DIV  = 7'b0000100,
        ST_TIME = 7'b0001000,
        ST_MUL  = 7'b0010000,
        ST_CORR = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

endpackage

FILE: rtl/lfsc_lane.sv
// ============================================================================
// lfsc_lane - one sensor lane
// Threshold compare, excess and signed weighted excess for one sensor.
// ============================================================================
module lfsc_lane import lfsc_pkg::*; #(
    parameter int SAMPLE_BITS = 10,
    parameter int WEIGHT = 0
) (
    input  logic                   i_clk,
    input  logic                   i_load,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_threshold,
    output logic                   o_dark,
    output logic [SAMPLE_BITS-1:0] o_excess,
    output logic signed [SAMPLE_BITS+11:0] o_weighted
);

    logic                   n_dark;
    logic [SAMPLE_BITS-1:0] n_excess;
    logic                   r_dark;
    logic [SAMPLE_BITS-1:0] r_excess;
    logic signed [SAMPLE_BITS+11:0] r_weighted;
    logic signed [11:0]     c_weight;

    assign c_weight = 12'(WEIGHT);

    // compare and excess
    always_comb begin
        n_dark = i_sample > i_threshold;
        n_excess = n_dark ? (i_sample - i_threshold) : '0;
    end

    // registered at item load; weighting is registered in the cycle after
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dark <= n_dark;
            r_excess <= n_excess;
        end
        r_weighted <= c_weight * $signed({1'b0, r_excess});
    end

    assign o_dark = r_dark;
    assign o_excess = r_excess;
    assign o_weighted = r_weighted;

endmodule

FILE: rtl/lfsc_divider.sv
// ============================================================================
// lfsc_divider - serial signed divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ============================================================================
module lfsc_divider import lfsc_pkg::*; #(
    parameter int NUM_BITS = 24,
    parameter int DEN_BITS = 14
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0]        i_den,
    output logic                       o_done,
    output logic signed [NUM_BITS-1:0] o_quot
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_q;
    logic [DEN_BITS:0]   r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic                r_neg;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [DEN_BITS+1:0] n_trial;
    logic [DEN_BITS:0]   n_shift;

    always_comb begin
        n_shift = {r_rem[DEN_BITS-1:0], r_q[NUM_BITS-1]};
        n_trial = {1'b0, n_shift} - {2'b00, r_den};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CNT_BITS'(NUM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num[NUM_BITS-1] ? NUM_BITS'(-i_num) : NUM_BITS'(i_num);
            r_neg <= i_num[NUM_BITS-1];
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!n_trial[DEN_BITS+1]) begin
                r_rem <= n_trial[DEN_BITS:0];
                r_q <= {r_q[NUM_BITS-2:0], 1'b1};
            end else begin
                r_rem <= n_shift;
                r_q <= {r_q[NUM_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? NUM_BITS'(-$signed(r_q)) : $signed(r_q);

endmodule

FILE: rtl/line_follow_steering_controller_core.sv
// ============================================================================
// line_follow_steering_controller_core - line follower steering core
// Eight-lane threshold/centroid front end, arm timers and a PID back end.
// ============================================================================
// One item at a time: a beat is taken in the idle state. For a normal pattern
// the result passes the lane state (excess, then weighted products), the
// divider start, the serial centroid division and its done, then the timers
// and PID sum, the reciprocal multiply for the divide by 100, the correction
// and the output register. The serial centroid divider is the longest step.
// Other patterns skip the divider; a turn action also skips the multiply and
// the correction. The next beat is taken as soon as the block is back in idle;
// a result still waiting in the output register only holds the following
// result in its output cycle.
module line_follow_steering_controller_core import lfsc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_index,
    input  logic [39:0]            i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample_0,
    input  logic [SAMPLE_BITS-1:0] i_sample_1,
    input  logic [SAMPLE_BITS-1:0] i_sample_2,
    input  logic [SAMPLE_BITS-1:0] i_sample_3,
    input  logic [SAMPLE_BITS-1:0] i_sample_4,
    input  logic [SAMPLE_BITS-1:0] i_sample_5,
    input  logic [SAMPLE_BITS-1:0] i_sample_6,
    input  logic [SAMPLE_BITS-1:0] i_sample_7,
    input  logic [31:0]            i_time_ms,
    input  logic                   i_clear_history,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [2:0]             o_action,
    output logic signed [8:0]      o_right_speed,
    output logic signed [8:0]      o_left_speed,
    output logic [1:0]             o_pattern_class,
    output logic signed [10:0]     o_error_used
);

    localparam int WB = SAMPLE_BITS + 12;     // weighted lane width
    localparam int SB = WB + 3;               // weighted sum width
    localparam int VB = SAMPLE_BITS + 3;      // excess sum width

    // configuration registers
    logic [39:0] r_thr_lo, r_thr_hi;
    logic [7:0]  r_kp, r_ki, r_kd, r_max;
    logic [1:0]  r_pref;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_lo <= '0;
            r_thr_hi <= '0;
            r_kp <= 8'd40;
            r_ki <= 8'd0;
            r_kd <= 8'd60;
            r_max <= 8'd200;
            r_pref <= PREF_LEFT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_THR_LO: r_thr_lo <= i_cfg_data;
                REG_THR_HI: r_thr_hi <= i_cfg_data;
                REG_KP:     r_kp <= i_cfg_data[7:0];
                REG_KI:     r_ki <= i_cfg_data[7:0];
                REG_KD:     r_kd <= i_cfg_data[7:0];
                REG_MAXSPD: r_max <= i_cfg_data[7:0];
                REG_TURN:   r_pref <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    t_state r_state;
    logic   r_lane_step;
    logic   r_out_valid;
    logic   w_load;
    logic   w_out_load;
    logic   w_div_done;
    logic   r_div_start;

    assign o_ready = (r_state == ST_IDLE);
    assign w_load = i_valid && o_ready;
    // output register takes a new result once the old one is gone or leaving
    assign w_out_load = (r_state == ST_OUT) && (!r_out_valid || i_ready);

    // lanes
    logic [SAMPLE_BITS-1:0] w_samples [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] w_dark;
    logic [SAMPLE_BITS-1:0] w_excess [SENSOR_COUNT];
    logic signed [WB-1:0]   w_weighted [SENSOR_COUNT];

    assign w_samples[0] = i_sample_0;
    assign w_samples[1] = i_sample_1;
    assign w_samples[2] = i_sample_2;
    assign w_samples[3] = i_sample_3;
    assign w_samples[4] = i_sample_4;
    assign w_samples[5] = i_sample_5;
    assign w_samples[6] = i_sample_6;
    assign w_samples[7] = i_sample_7;

    for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
        logic [SAMPLE_BITS-1:0] w_thr;
        if (g < 4) begin : g_lo
            assign w_thr = r_thr_lo[g*SAMPLE_BITS +: SAMPLE_BITS];
        end else begin : g_hi
            assign w_thr = r_thr_hi[(g-4)*SAMPLE_BITS +: SAMPLE_BITS];
        end
        lfsc_lane #(.SAMPLE_BITS(SAMPLE_BITS), .WEIGHT(-700 + 200*g)) u_lane (
            .i_clk       (i_clk),
            .i_load      (w_load),
            .i_sample    (w_samples[g]),
            .i_threshold (w_thr),
            .o_dark      (w_dark[g]),
            .o_excess    (w_excess[g]),
            .o_weighted  (w_weighted[g])
        );
    end

    // merge: sums over lanes, pattern class
    logic signed [SB-1:0] n_wsum;
    logic [VB-1:0]        n_vsum;
    logic [1:0]           n_cls;
    always_comb begin
        n_wsum = '0;
        n_vsum = '0;
        for (int k = 0; k < SENSOR_COUNT; k++) begin
            n_wsum = n_wsum + SB'(w_weighted[k]);
            n_vsum = n_vsum + VB'(w_excess[k]);
        end
        if (&w_dark) n_cls = CLS_DARK;
        else if (w_dark == '0) n_cls = CLS_LIGHT;
        else if (w_dark == 8'b0011_1100) n_cls = CLS_CENTRE;
        else n_cls = CLS_NORMAL;
    end

    logic [1:0]  r_cls;
    logic [31:0] r_now;
    logic        r_clr;
    logic signed [SB-1:0] r_wsum;
    logic [VB-1:0]        r_vsum;
    logic signed [SB-1:0] w_quot;

    lfsc_divider #(.NUM_BITS(SB), .DEN_BITS(VB)) u_cdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_wsum),
        .i_den   (r_vsum),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // state
    logic        r_jarm, r_darm;
    logic [31:0] r_jtime, r_dtime;
    logic signed [13:0] r_integ;
    logic signed [10:0] r_prev;
    logic signed [10:0] r_pos;

    // timer / decision logic
    logic        n_jarm, n_darm;
    logic [31:0] n_jtime, n_dtime, w_jel, w_del;
    logic [2:0]  n_action;
    logic signed [10:0] w_prev_eff, n_err;
    logic signed [14:0] w_isum;
    logic signed [13:0] n_integ;
    always_comb begin
        n_jarm = r_jarm;
        n_darm = r_darm;
        n_jtime = r_jtime;
        n_dtime = r_dtime;
        n_action = ACT_DRIVE;
        if (r_cls == CLS_DARK && !r_jarm && !r_darm) begin
            n_jarm = 1'b1;
            n_jtime = r_now;
        end
        w_jel = r_now - n_jtime;
        if (n_jarm) begin
            if (r_cls == CLS_LIGHT && w_jel >= JCT_SETTLE_MS) begin
                n_action = (r_pref == PREF_LEFT) ? ACT_LEFT :
                           (r_pref == PREF_RIGHT) ? ACT_RIGHT : ACT_STRAIGHT;
                n_jarm = 1'b0;
                n_jtime = '0;
            end else if (w_jel > ARM_TIMEOUT) begin
                n_jarm = 1'b0;
            end
        end
        w_del = '0;
        if (n_action == ACT_DRIVE) begin
            if (r_cls == CLS_CENTRE && !n_darm && !n_jarm) begin
                n_darm = 1'b1;
                n_dtime = r_now;
            end
            w_del = r_now - n_dtime;
            if (n_darm) begin
                if (r_cls == CLS_LIGHT && w_del >= DEND_SETTLE_MS) begin
                    n_action = (r_pref == PREF_RIGHT) ? ACT_SPIN_CW : ACT_SPIN_CCW;
                    n_darm = 1'b0;
                end else if (w_del > ARM_TIMEOUT) begin
                    n_darm = 1'b0;
                end
            end
        end
        w_prev_eff = r_clr ? 11'sd0 : r_prev;
        n_err = (r_cls == CLS_NORMAL) ? r_pos : w_prev_eff;
        w_isum = (r_clr ? 15'sd0 : 15'(r_integ)) + 15'(n_err);
        if (w_isum > 15'sd5000) n_integ = 14'sd5000;
        else if (w_isum < -15'sd5000) n_integ = -14'sd5000;
        else n_integ = 14'(w_isum);
    end

    // PID sum and divide by 100
    logic [2:0]  r_action;
    logic signed [10:0] r_err;
    logic signed [23:0] r_sum;
    logic        r_sum_neg;
    logic [42:0] r_prod;
    logic [20:0] w_mag;
    logic [14:0] w_cquot;
    logic signed [23:0] w_corr;

    // |sum| stays below 2^21; quotient magnitude below 2^15
    assign w_mag = r_sum[23] ? 21'(-r_sum) : r_sum[20:0];
    assign w_cquot = r_prod[CORR_SHIFT +: 15];
    assign w_corr = r_sum_neg ? -24'(w_cquot) : 24'(w_cquot);

    logic signed [24:0] w_rs, w_ls, w_lim;
    always_comb begin
        w_lim = 25'($signed({1'b0, r_max}));
        w_rs = w_lim - 25'(w_corr);
        w_ls = w_lim + 25'(w_corr);
        if (w_rs > w_lim) w_rs = w_lim;
        else if (w_rs < -w_lim) w_rs = -w_lim;
        if (w_ls > w_lim) w_ls = w_lim;
        else if (w_ls < -w_lim) w_ls = -w_lim;
    end

    logic [1:0] r_o_cls;
    logic [2:0] r_o_act;
    logic signed [8:0] r_o_rs, r_o_ls;
    logic signed [10:0] r_o_err;
    logic signed [13:0] r_new_integ;

    // control sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_lane_step <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_jarm <= 1'b0;
            r_darm <= 1'b0;
            r_jtime <= '0;
            r_dtime <= '0;
            r_integ <= '0;
            r_prev <= '0;
        end else begin
            r_div_start <= 1'b0;
            if (w_out_load) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_load) begin
                        r_state <= ST_LANE;
                        r_lane_step <= 1'b0;
                    end
                end
                ST_LANE: begin
                    // with r_lane_step set the weighted products are in
                    r_lane_step <= 1'b1;
                    if (r_lane_step) begin
                        if (n_cls == CLS_NORMAL && n_vsum != '0) begin
                            r_state <= ST_DIV;
                            r_div_start <= 1'b1;
                        end else begin
                            r_state <= ST_TIME;
                        end
                    end
                end
                ST_DIV: begin
                    if (w_div_done) r_state <= ST_TIME;
                end
                ST_TIME: begin
                    r_jarm <= n_jarm;
                    r_darm <= n_darm;
                    r_jtime <= n_jtime;
                    r_dtime <= n_dtime;
                    if (r_clr) begin
                        r_integ <= '0;
                        r_prev <= '0;
                    end
                    if (n_action == ACT_DRIVE) r_state <= ST_MUL;
                    else r_state <= ST_OUT;
                end
                ST_MUL: r_state <= ST_CORR;
                ST_CORR: begin
                    r_integ <= r_new_integ;
                    r_prev <= r_err;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_load) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_now <= i_time_ms;
            r_clr <= i_clear_history;
        end
        if (r_state == ST_LANE && r_lane_step) begin
            r_cls <= n_cls;
            r_wsum <= n_wsum;
            r_vsum <= n_vsum;
            // without a division the centroid falls back to last error (zero on clear)
            r_pos <= r_clr ? 11'sd0 : r_prev;
        end
        if (r_state == ST_DIV && w_div_done) r_pos <= 11'(w_quot);
        if (r_state == ST_TIME) begin
            r_action <= n_action;
            r_err <= n_err;
            r_new_integ <= n_integ;
        end
        // reciprocal multiply on the sum magnitude
        if (r_state == ST_MUL) begin
            r_prod <= w_mag * CORR_RECIP;
            r_sum_neg <= r_sum[23];
        end
        if (w_out_load) begin
            r_o_cls <= r_cls;
            r_o_act <= r_action;
            if (r_action == ACT_DRIVE) begin
                r_o_rs <= 9'(w_rs);
                r_o_ls <= 9'(w_ls);
                r_o_err <= r_err;
            end else begin
                r_o_rs <= '0;
                r_o_ls <= '0;
                r_o_err <= '0;
            end
        end
    end

    // PID sum registered in the state before the multiply
    always_ff @(posedge i_clk) begin
        if (r_state == ST_TIME) begin
            r_sum <= 24'($signed({1'b0, r_kp}) * n_err)
                   + 24'($signed({1'b0, r_ki}) * n_integ)
                   + 24'($signed({1'b0, r_kd}) * (12'(n_err) - 12'(w_prev_eff)));
        end
    end

    assign o_valid = r_out_valid;
    assign o_action = r_o_act;
    assign o_right_speed = r_o_rs;
    assign o_left_speed = r_o_ls;
    assign o_pattern_class = r_o_cls;
    assign o_error_used = r_o_err;

endmodule
